[rtl/core/qrenc_pkg.sv]
// Shared types, constants and helper functions for the QR data bit stream encoder.
package qrenc_pkg;

    // Command codes carried in the request tuser field
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_FILL  = 2'd2;

    // Segment modes; codes two and three both select byte mode
    localparam logic [1:0] MODE_NUM   = 2'd0;
    localparam logic [1:0] MODE_ALNUM = 2'd1;

    // Mode indicators sent ahead of the count field
    localparam logic [3:0] IND_NUM   = 4'h1;
    localparam logic [3:0] IND_ALNUM = 4'h2;
    localparam logic [3:0] IND_BYTE  = 4'h4;

    // Pad bytes, alternating
    localparam logic [7:0] PAD_FIRST  = 8'hEC;
    localparam logic [7:0] PAD_SECOND = 8'h11;

    // Configuration register map (word index)
    localparam int         CFG_ADDR_W = 4;
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_VERSION  = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;

    // Reset values of the configuration registers
    localparam logic [1:0]  MODE_RST     = 2'd2;
    localparam logic [5:0]  VERSION_RST  = 6'd1;
    localparam logic [14:0] CAPACITY_RST = 15'd152;

    // Depth of the queue between classifier and sequencer (power of two)
    localparam int Q_DEPTH = 2;

    // Segment phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA,
        PH_DONE
    } phase_t;

    // Operation kinds handed from the classifier to the sequencer
    typedef enum logic [1:0] {
        OP_BEGIN,
        OP_CHAR,
        OP_FILL
    } op_kind_t;

    // One queued operation
    typedef struct packed {
        op_kind_t    kind;
        logic [15:0] chunk_a;   // begin: indicator, char: data group
        logic [4:0]  len_a;     // zero when the character closes no group
        logic [15:0] chunk_b;   // begin: count field
        logic [4:0]  len_b;
        logic        term;      // char: segment ends, terminator follows
    } qe_t;

    // Width of the character count field
    function automatic logic [4:0] count_width(input logic [1:0] mode, input logic [5:0] ver);
        logic small_v;
        logic large_v;
        small_v = (ver < 6'd10);
        large_v = (ver > 6'd26);
        if (mode == MODE_NUM)
            return small_v ? 5'd10 : (large_v ? 5'd14 : 5'd12);
        else if (mode == MODE_ALNUM)
            return small_v ? 5'd9 : (large_v ? 5'd13 : 5'd11);
        else
            return small_v ? 5'd8 : 5'd16;
    endfunction

    // Alphanumeric character code; anything outside the set maps to zero
    function automatic logic [5:0] alnum_code(input logic [15:0] v);
        if (v >= 16'd48 && v <= 16'd57)
            return 6'(v - 16'd48);
        else if (v >= 16'd65 && v <= 16'd90)
            return 6'(v - 16'd55);
        else
        begin
            unique case (v)
                16'd32:  return 6'd36;
                16'd36:  return 6'd37;
                16'd37:  return 6'd38;
                16'd42:  return 6'd39;
                16'd43:  return 6'd40;
                16'd45:  return 6'd41;
                16'd46:  return 6'd42;
                16'd47:  return 6'd43;
                16'd58:  return 6'd44;
                default: return 6'd0;
            endcase
        end
    endfunction

endpackage

[rtl/core/qrenc_front.sv]
// Request classifier: decodes commands, groups characters and queues operations.
module qrenc_front
    import qrenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  cfg_mode,
    input  logic [5:0]  cfg_version,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] value
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    input  logic        s_tlast,
    input  logic        q_full,
    output logic        q_push,
    output qe_t         q_entry
);

    phase_t      phase_reg, phase_next;
    logic [9:0]  gv_reg, gv_next;
    logic [1:0]  gc_reg, gc_next;

    logic        accept;
    logic [4:0]  cw;
    logic [15:0] cnt;
    logic [3:0]  ind;
    logic [3:0]  digit;
    logic [15:0] num_chunk;
    logic [9:0]  gv_num;
    logic [1:0]  gc_inc;
    logic [5:0]  acode;
    logic [15:0] chunk;
    logic [4:0]  len;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Begin fields
    assign cw  = count_width(cfg_mode, cfg_version);
    assign cnt = (cw >= 5'd16) ? s_tdata : (s_tdata & ((16'd1 << cw) - 16'd1));
    always_comb
    begin
        unique case (cfg_mode)
            MODE_NUM:   ind = IND_NUM;
            MODE_ALNUM: ind = IND_ALNUM;
            default:    ind = IND_BYTE;
        endcase
    end

    // Character helpers; the numeric group is formed at full chunk width
    assign digit     = (s_tdata >= 16'd48 && s_tdata <= 16'd57) ? 4'(s_tdata - 16'd48) : 4'd0;
    assign num_chunk = 16'(gv_reg) * 16'd10 + 16'(digit);
    assign gv_num    = num_chunk[9:0];
    assign gc_inc    = gc_reg + 2'd1;
    assign acode     = alnum_code(s_tdata);

    // Classification and group state
    always_comb
    begin
        phase_next = phase_reg;
        gv_next    = gv_reg;
        gc_next    = gc_reg;
        q_push     = 1'b0;
        q_entry    = '0;
        chunk      = '0;
        len        = '0;
        if (accept)
        begin
            unique case (s_tuser)
                CMD_BEGIN:
                begin
                    phase_next      = PH_DATA;
                    gv_next         = '0;
                    gc_next         = '0;
                    q_push          = 1'b1;
                    q_entry.kind    = OP_BEGIN;
                    q_entry.chunk_a = 16'(ind);
                    q_entry.len_a   = 5'd4;
                    q_entry.chunk_b = cnt;
                    q_entry.len_b   = cw;
                end
                CMD_CHAR:
                begin
                    if (phase_reg == PH_DATA)
                    begin
                        unique case (cfg_mode)
                            MODE_NUM:
                            begin
                                if (gc_inc >= 2'd3)
                                begin
                                    chunk   = num_chunk;
                                    len     = 5'd10;
                                    gv_next = '0;
                                    gc_next = '0;
                                end
                                else if (s_tlast)
                                begin
                                    chunk   = num_chunk;
                                    len     = (gc_inc == 2'd2) ? 5'd7 : 5'd4;
                                    gv_next = '0;
                                    gc_next = '0;
                                end
                                else
                                begin
                                    gv_next = gv_num;
                                    gc_next = gc_inc;
                                end
                            end
                            MODE_ALNUM:
                            begin
                                if (gc_reg != 2'd0)
                                begin
                                    chunk   = 16'(gv_reg * 16'd45 + 16'(acode));
                                    len     = 5'd11;
                                    gv_next = '0;
                                    gc_next = '0;
                                end
                                else if (s_tlast)
                                begin
                                    chunk = 16'(acode);
                                    len   = 5'd6;
                                end
                                else
                                begin
                                    gv_next = 10'(acode);
                                    gc_next = 2'd1;
                                end
                            end
                            default:
                            begin
                                chunk = {8'h00, s_tdata[7:0]};
                                len   = 5'd8;
                            end
                        endcase
                        if (s_tlast)
                            phase_next = PH_DONE;
                        q_push          = (len != 5'd0) || s_tlast;
                        q_entry.kind    = OP_CHAR;
                        q_entry.chunk_a = chunk;
                        q_entry.len_a   = len;
                        q_entry.term    = s_tlast;
                    end
                end
                CMD_FILL:
                begin
                    if (phase_reg == PH_DONE)
                    begin
                        q_push       = 1'b1;
                        q_entry.kind = OP_FILL;
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            gv_reg    <= '0;
            gc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            gv_reg    <= gv_next;
            gc_reg    <= gc_next;
        end
    end

endmodule

[rtl/core/qrenc_queue.sv]
// Short operation queue between the classifier and the output sequencer.
module qrenc_queue
    import qrenc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  qe_t  push_entry,
    output logic full,
    input  logic pop,
    output qe_t  head,
    output logic head_valid
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    qe_t              slots_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointers wrap naturally as the depth is a power of two
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[rtl/core/qrenc_back.sv]
// Output sequencer: bit accounting, terminator, pad bytes and the output register.
module qrenc_back
    import qrenc_pkg::*;
#(
    parameter int MAX_DATA_BITS = 32768
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [14:0] cfg_capacity,
    input  qe_t         head,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [15:0] chunk, [20:16] chunk_len, [23:21] zero
    output logic        m_tuser,    // [0] overflow
    output logic        m_tlast     // end_of_stream
);

    localparam int BITS_W = $clog2(MAX_DATA_BITS + 1);
    localparam int CMP_W  = (BITS_W + 1 > 16) ? BITS_W + 1 : 16;
    localparam logic [CMP_W-1:0] MAX_BITS = CMP_W'(MAX_DATA_BITS);

    logic [BITS_W-1:0] bits_reg, bits_next;
    logic              ovf_reg, ovf_next;
    logic              pad_toggle_reg, pad_toggle_next;
    logic              step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [15:0]       chunk_reg, chunk_next;
    logic [4:0]        len_reg, len_next;
    logic              eos_reg, eos_next;
    logic              ovf_out_reg, ovf_out_next;

    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  bits_ext;
    logic [CMP_W-1:0]  room;
    logic              below_cap;
    logic [2:0]        term_t;
    logic [2:0]        term_align;
    logic [4:0]        term_len;
    logic [3:0]        pad_n;
    logic [7:0]        pad_byte;
    logic [15:0]       pad_chunk;

    logic              restart;
    logic              want;
    logic              last_step;
    logic [15:0]       e_chunk;
    logic [4:0]        e_len;
    logic [CMP_W-1:0]  base_bits;
    logic              base_ovf;
    logic [CMP_W-1:0]  sum;
    logic [CMP_W-1:0]  after;
    logic              out_free;
    logic              advance;
    logic              fire;

    // Remaining room against capacity
    assign cap_ext   = CMP_W'(cfg_capacity);
    assign bits_ext  = CMP_W'(bits_reg);
    assign below_cap = bits_ext < cap_ext;
    assign room      = cap_ext - bits_ext;

    // Terminator: up to four zeros, then zeros to a byte boundary
    assign term_t     = !below_cap ? 3'd0 : ((room >= CMP_W'(4)) ? 3'd4 : room[2:0]);
    assign term_align = bits_reg[2:0] + term_t;
    assign term_len   = 5'(term_t) + ((term_align != 3'd0) ? (5'd8 - 5'(term_align)) : 5'd0);

    // Pad byte, cut to the remaining room
    assign pad_n     = (room >= CMP_W'(8)) ? 4'd8 : room[3:0];
    assign pad_byte  = pad_toggle_reg ? PAD_SECOND : PAD_FIRST;
    assign pad_chunk = {8'h00, pad_byte >> (4'd8 - pad_n)};

    // Select what the head operation sends at this step
    always_comb
    begin
        want      = 1'b0;
        last_step = 1'b1;
        e_chunk   = '0;
        e_len     = '0;
        unique case (head.kind)
            OP_BEGIN:
            begin
                want      = 1'b1;
                last_step = step_reg;
                e_chunk   = step_reg ? head.chunk_b : head.chunk_a;
                e_len     = step_reg ? head.len_b : head.len_a;
            end
            OP_CHAR:
            begin
                if (!step_reg)
                begin
                    want      = (head.len_a != 5'd0);
                    last_step = !head.term;
                    e_chunk   = head.chunk_a;
                    e_len     = head.len_a;
                end
                else
                begin
                    want    = (term_len != 5'd0);
                    e_chunk = '0;
                    e_len   = term_len;
                end
            end
            OP_FILL:
            begin
                want    = below_cap;
                e_chunk = pad_chunk;
                e_len   = 5'(pad_n);
            end
            default:
            begin
                want = 1'b0;
            end
        endcase
    end

    // Bit count update, saturating, with end and overflow flags
    assign restart   = (head.kind == OP_BEGIN) && !step_reg;
    assign base_bits = restart ? '0 : bits_ext;
    assign base_ovf  = restart ? 1'b0 : ovf_reg;
    assign sum       = base_bits + CMP_W'(e_len);
    assign after     = (sum > MAX_BITS) ? MAX_BITS : sum;

    assign out_free = !valid_reg || m_tready;
    assign advance  = head_valid && (!want || out_free);
    assign fire     = advance && want;
    assign pop      = advance && last_step;

    always_comb
    begin
        bits_next       = bits_reg;
        ovf_next        = ovf_reg;
        pad_toggle_next = pad_toggle_reg;
        step_next       = step_reg;
        valid_next      = valid_reg && !m_tready;
        chunk_next      = chunk_reg;
        len_next        = len_reg;
        eos_next        = eos_reg;
        ovf_out_next    = ovf_out_reg;
        if (advance)
        begin
            step_next = !last_step;
            if (restart)
                pad_toggle_next = 1'b0;
            else if (fire && head.kind == OP_FILL)
                pad_toggle_next = !pad_toggle_reg;
        end
        if (fire)
        begin
            bits_next    = after[BITS_W-1:0];
            ovf_next     = base_ovf || (after > cap_ext);
            valid_next   = 1'b1;
            chunk_next   = e_chunk;
            len_next     = e_len;
            eos_next     = (base_bits < cap_ext) && (after >= cap_ext);
            ovf_out_next = base_ovf || (after > cap_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg       <= '0;
            ovf_reg        <= 1'b0;
            pad_toggle_reg <= 1'b0;
            step_reg       <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            bits_reg       <= bits_next;
            ovf_reg        <= ovf_next;
            pad_toggle_reg <= pad_toggle_next;
            step_reg       <= step_next;
            valid_reg      <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        chunk_reg   <= chunk_next;
        len_reg     <= len_next;
        eos_reg     <= eos_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, len_reg, chunk_reg};
    assign m_tuser  = ovf_out_reg;
    assign m_tlast  = eos_reg;

endmodule

[rtl/core/qr_data_bitstream_encoder.sv]
// Top level of the QR data bit stream encoder: configuration port and block wiring.
// The encoder accepts one request per cycle while the queue is not full. A classifier
// decodes each request (begin, character, fill), groups numeric and alphanumeric characters
// and places an operation in a two-entry queue; an output sequencer turns each operation
// into stream chunks, one chunk per cycle unless stalled, through a registered output. A
// begin request gives two chunks (mode indicator, count field) and a final character gives
// its chunk plus a terminator chunk when the terminator is not empty, so those stay at the
// queue head for both parts; other requests leave it as their chunk is sent, which sets the
// sustained rate at one request per cycle for character and fill traffic. A request's first
// chunk passes through a queue slot and then the output register. A character that only
// extends a group, a character outside a segment, a fill before the segment has ended and
// an unknown command never enter the queue; a fill once capacity is reached does enter it
// and leaves it without a chunk. The user writes mode, version and capacity_bits over the
// APB port only while the stream is quiet; the block itself does not enforce it.
module qr_data_bitstream_encoder
    import qrenc_pkg::*;
#(
    parameter int MAX_DATA_BITS = 32768
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,    // [15:0] value
    input  logic [1:0]            s_tuser,    // [1:0] cmd
    input  logic                  s_tlast,    // last character
    // Chunk stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,    // [15:0] chunk, [20:16] chunk_len, [23:21] zero
    output logic                  m_tuser,    // [0] overflow
    output logic                  m_tlast     // end_of_stream
);

    logic [1:0]  mode_reg;
    logic [5:0]  version_reg;
    logic [14:0] cap_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    logic        q_push;
    qe_t         q_entry;
    logic        q_full;
    logic        q_pop;
    qe_t         q_head;
    logic        q_head_valid;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RST;
            version_reg <= VERSION_RST;
            cap_reg     <= CAPACITY_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MODE:     mode_reg    <= pwdata[1:0];
                REG_VERSION:  version_reg <= pwdata[5:0];
                REG_CAPACITY: cap_reg     <= pwdata[14:0];
                default:      mode_reg    <= mode_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (cfg_idx)
            REG_MODE:     prdata = 32'(mode_reg);
            REG_VERSION:  prdata = 32'(version_reg);
            REG_CAPACITY: prdata = 32'(cap_reg);
            default:      prdata = '0;
        endcase
    end

    qrenc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_mode    (mode_reg),
        .cfg_version (version_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    qrenc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    qrenc_back #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_capacity (cap_reg),
        .head         (q_head),
        .head_valid   (q_head_valid),
        .pop          (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

[rtl/core/qrenc_checker.sv]
// Port-level checks for the QR data bit stream encoder, bound to the top level.
module qrenc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A held chunk keeps its contents until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("chunk changed while stalled");

    // Every chunk carries between one and sixteen bits
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20:16] != 5'd0) && (m_tdata[20:16] <= 5'd16))
        else $error("chunk length out of range");

    // Filler bits above the length field stay zero
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:21] == 3'b000))
        else $error("tdata filler bits set");

    // No chunk appears straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("chunk valid right after reset");

endmodule

bind qr_data_bitstream_encoder qrenc_checker u_qrenc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[sim/qr_data_bitstream_encoder_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the QR data bit stream encoder: directed and random requests.
module qr_data_bitstream_encoder_test;
    import qrenc_pkg::*;

    localparam int         MAX_BITS     = 32768;
    localparam int         IDLE_PERCENT = 29;
    localparam int         TAIL_CYCLES  = 8;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         RANDOM_ITEMS = 440;
    localparam int         OVERRUN_LEN  = 40;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // One expected chunk as the encoder should return it
    typedef struct {
        logic [15:0] chunk;
        logic [4:0]  len;
        logic        eos;
        logic        ovf;
    } chunk_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;    // [15:0] value
    logic [1:0]            s_tuser;    // [1:0] cmd
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;    // [15:0] chunk, [20:16] chunk_len, [23:21] zero
    logic                  m_tuser;    // [0] overflow
    logic                  m_tlast;

    chunk_t expected_chunks[$];
    int     mismatches         = 0;
    int     cycle_count        = 0;
    int     effective_requests = 0;
    bit     steady             = 1'b0;
    string  alnum_table        = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";

    // Encoder model: configuration and segment state
    logic [1:0]  cfg_mode;
    logic [5:0]  cfg_version;
    logic [14:0] cfg_capacity;
    phase_t      seg_phase;
    int          grp_value;
    int          grp_count;
    int          bit_count;
    bit          pad_odd;
    bit          ovf_flag;

    qr_data_bitstream_encoder #(
        .MAX_DATA_BITS (MAX_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void note_mismatch(string text);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", text);
    endfunction

    // Width of the character count field; mode three counts as byte
    function automatic int count_field_bits();
        if (cfg_version < 6'd10)
            return (cfg_mode == MODE_NUM) ? 10 : ((cfg_mode == MODE_ALNUM) ? 9 : 8);
        if (cfg_version > 6'd26)
            return (cfg_mode == MODE_NUM) ? 14 : ((cfg_mode == MODE_ALNUM) ? 13 : 16);
        return (cfg_mode == MODE_NUM) ? 12 : ((cfg_mode == MODE_ALNUM) ? 11 : 16);
    endfunction

    // Position in the 45-symbol set, zero for anything outside it
    function automatic int alnum_index(logic [15:0] value);
        for (int i = 0; i < 45; i++)
            if (value == {8'h00, alnum_table[i]})
                return i;
        return 0;
    endfunction

    // Account for one chunk and queue it as expected
    function automatic void push_chunk(int chunk, int len);
        chunk_t item;
        int     prior;
        prior     = bit_count;
        bit_count = (prior + len > MAX_BITS) ? MAX_BITS : prior + len;
        if (bit_count > cfg_capacity)
            ovf_flag = 1'b1;
        item.chunk = chunk[15:0];
        item.len   = len[4:0];
        item.eos   = (prior < cfg_capacity) && (bit_count >= cfg_capacity);
        item.ovf   = ovf_flag;
        expected_chunks.insert(expected_chunks.size(), item);
    endfunction

    // Predict the chunks of one accepted request; returns 0 if the request is ignored
    function automatic bit encode_request(logic [1:0] cmd, logic [15:0] value, logic last);
        int         width;
        int         code;
        int         chunk;
        int         len;
        int         rem;
        int         tail;
        int         spill;
        int         n;
        logic [7:0] pad;
        chunk = 0;
        len   = 0;
        case (cmd)
            CMD_BEGIN:
            begin
                width     = count_field_bits();
                grp_value = 0;
                grp_count = 0;
                bit_count = 0;
                pad_odd   = 1'b0;
                ovf_flag  = 1'b0;
                seg_phase = PH_DATA;
                push_chunk((cfg_mode == MODE_NUM) ? IND_NUM :
                           ((cfg_mode == MODE_ALNUM) ? IND_ALNUM : IND_BYTE), 4);
                push_chunk((width >= 16) ? int'(value) : (int'(value) & ((1 << width) - 1)),
                           width);
                return 1'b1;
            end
            CMD_CHAR:
            begin
                if (seg_phase != PH_DATA)
                    return 1'b0;
                if (cfg_mode == MODE_NUM)
                begin
                    // digits outside 0..9 count as zero; leading zeros keep full width
                    grp_value = grp_value * 10 +
                                ((value >= 16'd48 && value <= 16'd57) ? int'(value) - 48 : 0);
                    grp_count++;
                    if (grp_count >= 3 || last)
                    begin
                        chunk     = grp_value;
                        len       = (grp_count >= 3) ? 10 : ((grp_count == 2) ? 7 : 4);
                        grp_value = 0;
                        grp_count = 0;
                    end
                end
                else if (cfg_mode == MODE_ALNUM)
                begin
                    code = alnum_index(value);
                    if (grp_count != 0)
                    begin
                        chunk     = 45 * grp_value + code;
                        len       = 11;
                        grp_value = 0;
                        grp_count = 0;
                    end
                    else if (last)
                    begin
                        chunk = code;
                        len   = 6;
                    end
                    else
                    begin
                        grp_value = code;
                        grp_count = 1;
                    end
                end
                else
                begin
                    chunk = value[7:0];
                    len   = 8;
                end
                if (len != 0)
                    push_chunk(chunk, len);
                // terminator: up to four zeros within capacity, then byte alignment
                if (last)
                begin
                    rem       = (cfg_capacity > bit_count) ? cfg_capacity - bit_count : 0;
                    tail      = (rem < 4) ? rem : 4;
                    spill     = (bit_count + tail) % 8;
                    tail      = tail + ((spill != 0) ? 8 - spill : 0);
                    seg_phase = PH_DONE;
                    if (tail != 0)
                        push_chunk(0, tail);
                end
                return 1'b1;
            end
            CMD_FILL:
            begin
                if (seg_phase != PH_DONE || bit_count >= cfg_capacity)
                    return 1'b0;
                rem     = cfg_capacity - bit_count;
                n       = (rem < 8) ? rem : 8;
                pad     = pad_odd ? PAD_SECOND : PAD_FIRST;
                pad_odd = !pad_odd;
                push_chunk(int'(pad) >> (8 - n), n);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
        return 1'b0;
    endfunction

    // Character code suited to the current mode, sometimes an arbitrary value
    function automatic logic [15:0] pick_character();
        if ($urandom_range(99) < 15)
            return 16'($urandom);
        case (cfg_mode)
            MODE_NUM:   return 16'(48 + $urandom_range(9));
            MODE_ALNUM: return {8'h00, alnum_table[$urandom_range(44)]};
            default:    return 16'($urandom_range(255));
        endcase
    endfunction

    // Send one request, with a random gap ahead of it, and predict its chunks
    task automatic send_request(logic [1:0] cmd, logic [15:0] value, logic last);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= cmd;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (encode_request(cmd, value, last))
            effective_requests++;
    endtask

    task automatic send_text(string text, bit close);
        for (int i = 0; i < text.len(); i++)
            send_request(CMD_CHAR, {8'h00, text[i]}, close && (i == text.len() - 1));
    endtask

    task automatic send_fills(int count);
        repeat (count) send_request(CMD_FILL, 16'($urandom), 1'($urandom));
    endtask

    // Wait for every expected chunk, then for stray ones from no-result requests
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (expected_chunks.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read back of the same register
    task automatic write_register(logic [1:0] index, logic [31:0] data);
        logic [31:0] readback;
        logic [31:0] mask;
        mask = (index == REG_MODE) ? 32'h3 : ((index == REG_VERSION) ? 32'h3F : 32'h7FFF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (index)
            REG_MODE:    cfg_mode     = data[1:0];
            REG_VERSION: cfg_version  = data[5:0];
            default:     cfg_capacity = data[14:0];
        endcase
        if (readback !== (data & mask))
            note_mismatch($sformatf("register %0d read %h, expected %h",
                                    index, readback, data & mask));
    endtask

    task automatic configure(logic [1:0] mode, logic [5:0] version, logic [14:0] capacity);
        drain_stream();
        write_register(REG_MODE, 32'(mode));
        write_register(REG_VERSION, 32'(version));
        write_register(REG_CAPACITY, 32'(capacity));
    endtask

    // Reset settings: byte mode, small version, 152 bits; ignored requests around it
    task automatic test_reset_byte_stream();
        send_request(CMD_CHAR, 16'h0041, 1'b1);
        send_request(CMD_FILL, 16'h0000, 1'b0);
        send_request(CMD_BEGIN, 16'hFFFF, 1'b0);
        send_request(CMD_FILL, 16'hFFFF, 1'b1);
        send_request(CMD_CHAR, 16'h0000, 1'b0);
        send_request(CMD_CHAR, 16'hFFFF, 1'b0);
        send_request(CMD_CHAR, 16'h5AA5, 1'b1);
        send_fills(15);
        send_request(CMD_CHAR, 16'h0042, 1'b1);
        send_request(CMD_UNUSED, 16'hFFFF, 1'b1);
    endtask

    // Numeric groups, leading zeros, invalid digits, both tail lengths
    task automatic test_numeric_groups();
        configure(MODE_NUM, 6'd10, 15'd120);
        send_request(CMD_BEGIN, 16'hFFFF, 1'b0);
        send_text("007999A", 1'b0);
        send_request(CMD_CHAR, 16'hFFFF, 1'b0);
        send_text("5", 1'b1);
        send_fills(3);
        configure(MODE_NUM, 6'd27, 15'd120);
        send_request(CMD_BEGIN, 16'h3FFF, 1'b0);
        send_text("12", 1'b1);
        configure(MODE_NUM, 6'd0, 15'd120);
        send_request(CMD_BEGIN, 16'h0001, 1'b0);
        send_text("8", 1'b1);
    endtask

    // Alphanumeric pairs, an invalid code and a lone last character
    task automatic test_alphanumeric_pairs();
        configure(MODE_ALNUM, 6'd40, 15'd400);
        send_request(CMD_BEGIN, 16'h1FFF, 1'b0);
        send_text("AC$:", 1'b0);
        send_request(CMD_CHAR, 16'h007A, 1'b0);
        send_text(" ", 1'b1);
        send_request(CMD_BEGIN, 16'h0001, 1'b0);
        send_text("Z", 1'b1);
        send_fills(2);
    endtask

    // Zero and odd capacities, mode three, out-of-range version, restart
    task automatic test_capacity_limits();
        configure(2'd3, 6'd63, 15'd0);
        send_request(CMD_BEGIN, 16'h8001, 1'b0);
        send_text("Q", 1'b1);
        send_fills(1);
        configure(2'd2, 6'd1, 15'd27);
        send_request(CMD_BEGIN, 16'h0000, 1'b0);
        send_text("X", 1'b1);
        send_fills(2);
        send_request(CMD_BEGIN, 16'h0002, 1'b0);
        send_text("1", 1'b0);
        send_request(CMD_BEGIN, 16'h0001, 1'b1);
        send_text("2", 1'b1);
        configure(2'd2, 6'd26, 15'd23648);
        send_request(CMD_BEGIN, 16'h0100, 1'b0);
        send_text("k", 1'b1);
        send_fills(2);
    endtask

    // Long byte segment that runs well past a small capacity
    task automatic test_capacity_overrun();
        configure(2'd2, 6'd40, 15'd200);
        send_request(CMD_BEGIN, 16'hFFFF, 1'b0);
        for (int i = 1; i <= OVERRUN_LEN; i++)
            send_request(CMD_CHAR, pick_character(), i == OVERRUN_LEN);
        send_fills(2);
    endtask

    // Random segments under random settings, with broken sequences and noise
    task automatic test_random_segments();
        int          start;
        int          done_items;
        int          nchars;
        int          needed;
        bit          abort;
        logic [5:0]  ver;
        logic [14:0] cap;
        start = effective_requests;
        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            steady = (done_items >= 250) && (done_items < 370);
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(4))
                    0:       ver = 6'($urandom_range(0, 9));
                    1:       ver = 6'($urandom_range(10, 26));
                    2:       ver = 6'($urandom_range(27, 40));
                    3:       ver = 6'($urandom_range(41, 63));
                    default: ver = 6'($urandom_range(1, 9));
                endcase
                if ($urandom_range(99) < 85)
                    cap = 15'($urandom_range(0, 320));
                else
                    cap = 15'($urandom_range(0, 23648));
                configure(2'($urandom_range(3)), ver, cap);
            end
            // well-formed segment, now and then left without its last character
            abort = ($urandom_range(99) < 8);
            send_request(CMD_BEGIN, 16'($urandom), 1'($urandom));
            nchars = $urandom_range(1, 20);
            for (int i = 1; i <= nchars; i++)
                send_request(CMD_CHAR, pick_character(), !abort && (i == nchars));
            if (!abort)
            begin
                needed = (cfg_capacity > bit_count) ? (cfg_capacity - bit_count + 7) / 8 : 0;
                if (needed > 30)
                    needed = 30;
                if ($urandom_range(99) < 70)
                    send_fills(needed + $urandom_range(2));
                else
                    send_fills($urandom_range(needed));
            end
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 3))
                    send_request(2'($urandom), 16'($urandom), 1'($urandom));
            done_items = effective_requests - start;
        end
        steady = 1'b0;
    endtask

    // Chunk checker and receiver back-pressure
    always @(posedge clk)
    begin : check_chunks
        chunk_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chunks.size() == 0)
                note_mismatch($sformatf("unexpected chunk %h len %0d",
                                        m_tdata[15:0], m_tdata[20:16]));
            else
            begin
                want = expected_chunks.pop_front();
                if (m_tdata !== {3'b000, want.len, want.chunk} ||
                    m_tlast !== want.eos || m_tuser !== want.ovf)
                    note_mismatch($sformatf(
                        "chunk %h len %0d eos %b ovf %b, expected %h len %0d eos %b ovf %b",
                        m_tdata[15:0], m_tdata[20:16], m_tlast, m_tuser,
                        want.chunk, want.len, want.eos, want.ovf));
            end
        end
        m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_BEGIN;
        s_tlast  <= 1'b0;
        cfg_mode     = MODE_RST;
        cfg_version  = VERSION_RST;
        cfg_capacity = CAPACITY_RST;
        seg_phase    = PH_IDLE;
        grp_value    = 0;
        grp_count    = 0;
        bit_count    = 0;
        pad_odd      = 1'b0;
        ovf_flag     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_byte_stream();
        test_numeric_groups();
        test_alphanumeric_pairs();
        test_capacity_limits();
        test_capacity_overrun();
        test_random_segments();
        drain_stream();
        if (mismatches == 0 && expected_chunks.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[qr_data_bitstream_encoder.f]
rtl/core/qrenc_pkg.sv
rtl/core/qrenc_front.sv
rtl/core/qrenc_queue.sv
rtl/core/qrenc_back.sv
rtl/core/qr_data_bitstream_encoder.sv
rtl/core/qrenc_checker.sv
sim/qr_data_bitstream_encoder_test.sv
